### hw/rtl/wsp_pkg.sv
// Shared types and constants for the WAV stream parser.
// No dependencies; used by every module of the block.
package wsp_pkg;

  // Queue depth between parser and output stage
  localparam int QueueDepth = 4;

  // Tags as little-endian words, first file byte lowest
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  // Byte positions within the fmt body
  localparam logic [23:0] FmtChanLo = 24'd2;
  localparam logic [23:0] FmtChanHi = 24'd3;
  localparam logic [23:0] FmtRate0  = 24'd4;
  localparam logic [23:0] FmtRate1  = 24'd5;
  localparam logic [23:0] FmtRate2  = 24'd6;
  localparam logic [23:0] FmtRate3  = 24'd7;
  localparam logic [23:0] FmtBitsLo = 24'd14;
  localparam logic [23:0] FmtBitsHi = 24'd15;

  localparam logic [31:0] HeaderLast = 32'd11;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_CHUNK_ID   = 3'd1,
    PH_CHUNK_SIZE = 3'd2,
    PH_FMT        = 3'd3,
    PH_DATA       = 3'd4,
    PH_SKIP       = 3'd5,
    PH_IDLE       = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAIR = 2'd0,
    KIND_FMT  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Word passed from parser to output stage.
  // Pair: data[31:0] holds the raw frame bytes.
  // Format: data = {rate, bits, channels}.
  typedef struct packed {
    kind_t       kind;
    logic        mono;
    logic        wide8;
    logic [63:0] data;
  } wsp_rec_t;

endpackage

### hw/rtl/wsp_front.sv
// Parser front end: RIFF/WAVE walk, fmt capture, frame gathering.
// Depends on wsp_pkg; pushes one word per result into wsp_queue.
module wsp_front
  import wsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  in_byte,
  input  logic        in_start_of_file,
  output logic        rec_push,
  output wsp_rec_t    rec
);

  phase_t      phase_r, phase_nxt, ph_c;
  logic [31:0] bl_r, bl_nxt, bl_c;
  logic [31:0] tag_r, tag_nxt, tag_c;
  logic [31:0] rlen_r, rlen_nxt, rlen_c;
  logic [31:0] off_r, off_nxt, off_c;
  logic [15:0] ch_r, ch_nxt, ch_c;
  logic [15:0] bits_r, bits_nxt, bits_c;
  logic [31:0] rate_r, rate_nxt, rate_c;
  logic [23:0] fb_r, fb_nxt, fb_c;
  logic [1:0]  fi_r, fi_nxt, fi_c;
  logic        seen_r, seen_nxt, seen_c;

  logic        err, fin, next_chunk, chunk_ok, sat;
  logic [31:0] bshift, bl_sz, bl_dec, frame_all;
  logic [4:0]  fi_sh;
  logic        wide8, mono;
  logic [2:0]  flen;

  // start mark restarts the parser before the byte is taken
  always_comb begin
    if (in_start_of_file) begin
      ph_c = PH_HEADER; bl_c = '0; tag_c = '0; rlen_c = '0; off_c = '0;
      ch_c = '0; bits_c = '0; rate_c = '0; fb_c = '0; fi_c = '0; seen_c = 1'b0;
    end else begin
      ph_c = phase_r; bl_c = bl_r; tag_c = tag_r; rlen_c = rlen_r; off_c = off_r;
      ch_c = ch_r; bits_c = bits_r; rate_c = rate_r; fb_c = fb_r; fi_c = fi_r;
      seen_c = seen_r;
    end
  end

  assign sat      = (off_c == 32'hFFFF_FFFF);
  assign chunk_ok = (({1'b0, off_c} + (sat ? 33'd8 : 33'd9)) < {1'b0, rlen_c});
  assign fi_sh    = {fi_c, 3'b000};
  assign bshift   = {24'b0, in_byte} << fi_sh;
  assign bl_sz    = bl_c | bshift;
  assign bl_dec   = bl_c - 32'd1;
  assign wide8    = (bits_c == 16'd8);
  assign mono     = (ch_c == 16'd1);
  assign flen     = wide8 ? (mono ? 3'd1 : 3'd2) : (mono ? 3'd2 : 3'd4);
  assign frame_all = {8'b0, fb_c} | bshift;

  always_comb begin
    phase_nxt = phase_r; bl_nxt = bl_r; tag_nxt = tag_r; rlen_nxt = rlen_r;
    off_nxt = off_r; ch_nxt = ch_r; bits_nxt = bits_r; rate_nxt = rate_r;
    fb_nxt = fb_r; fi_nxt = fi_r; seen_nxt = seen_r;
    err = 1'b0; fin = 1'b0; next_chunk = 1'b0;
    rec_push = 1'b0;
    rec = '0;
    if (take) begin
      phase_nxt = ph_c; bl_nxt = bl_c; tag_nxt = tag_c; rlen_nxt = rlen_c;
      off_nxt = off_c; ch_nxt = ch_c; bits_nxt = bits_c; rate_nxt = rate_c;
      fb_nxt = fb_c; fi_nxt = fi_c; seen_nxt = seen_c;
      if (ph_c != PH_IDLE) begin
        off_nxt = sat ? off_c : off_c + 32'd1;
        case (ph_c)
          PH_HEADER: begin
            if (off_c[31:2] == '0) begin
              if (in_byte != TagRiff[{off_c[1:0], 3'b000} +: 8]) err = 1'b1;
            end else if (off_c[31:3] == '0) begin
              rlen_nxt = rlen_c | ({24'b0, in_byte} << {off_c[1:0], 3'b000});
            end else begin
              if (in_byte != TagWave[{off_c[1:0], 3'b000} +: 8]) begin
                err = 1'b1;
              end else if (off_c >= HeaderLast) begin
                next_chunk = 1'b1;
              end
            end
          end
          PH_CHUNK_ID: begin
            tag_nxt = tag_c | bshift;
            if (fi_c == 2'd3) begin
              fi_nxt    = '0;
              bl_nxt    = '0;
              phase_nxt = PH_CHUNK_SIZE;
            end else begin
              fi_nxt = fi_c + 2'd1;
            end
          end
          PH_CHUNK_SIZE: begin
            bl_nxt = bl_sz;
            if (fi_c == 2'd3) begin
              fi_nxt = '0;
              fb_nxt = '0;
              if (tag_c == TagFmt) begin
                ch_nxt    = '0;
                bits_nxt  = '0;
                rate_nxt  = '0;
                phase_nxt = PH_FMT;
                if (bl_sz == '0) fin = 1'b1;
              end else if (tag_c == TagData) begin
                if (!seen_c) begin
                  err = 1'b1;
                end else begin
                  phase_nxt = PH_DATA;
                  if (bl_sz == '0) next_chunk = 1'b1;
                end
              end else begin
                phase_nxt = PH_SKIP;
                if (bl_sz == '0) next_chunk = 1'b1;
              end
            end else begin
              fi_nxt = fi_c + 2'd1;
            end
          end
          PH_FMT: begin
            case (fb_c)
              FmtChanLo: ch_nxt[7:0]  = in_byte;
              FmtChanHi: ch_nxt[15:8] = in_byte;
              FmtRate0, FmtRate1, FmtRate2, FmtRate3:
                rate_nxt = rate_c | ({24'b0, in_byte} << {fb_c[1:0], 3'b000});
              FmtBitsLo: bits_nxt[7:0]  = in_byte;
              FmtBitsHi: bits_nxt[15:8] = in_byte;
              default: ;
            endcase
            if (fb_c != 24'hFF_FFFF) fb_nxt = fb_c + 24'd1;
            bl_nxt = bl_dec;
            if (bl_dec == '0) begin
              fb_nxt = '0;
              fin    = 1'b1;
            end
          end
          PH_DATA: begin
            if (({1'b0, fi_c} + 3'd1) < flen) begin
              fb_nxt = fb_c | bshift[23:0];
              fi_nxt = fi_c + 2'd1;
            end else begin
              rec_push   = 1'b1;
              rec.kind   = KIND_PAIR;
              rec.mono   = mono;
              rec.wide8  = wide8;
              rec.data   = {32'b0, frame_all};
              fi_nxt     = '0;
              fb_nxt     = '0;
            end
            bl_nxt = bl_dec;
            if (bl_dec == '0) begin
              fi_nxt     = '0;
              fb_nxt     = '0;
              next_chunk = 1'b1;
            end
          end
          PH_SKIP: begin
            bl_nxt = bl_dec;
            if (bl_dec == '0) next_chunk = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase

        // closing a fmt chunk: only 8 or 16 bit depths are valid
        if (fin) begin
          if (bits_nxt != 16'd8 && bits_nxt != 16'd16) begin
            err = 1'b1;
          end else begin
            seen_nxt   = 1'b1;
            rec_push   = 1'b1;
            rec.kind   = KIND_FMT;
            rec.data   = {rate_nxt, bits_nxt, ch_nxt};
            next_chunk = 1'b1;
          end
        end

        if (err) begin
          rec_push  = 1'b1;
          rec       = '0;
          rec.kind  = KIND_ERR;
          phase_nxt = PH_IDLE;
        end else if (next_chunk) begin
          if (chunk_ok) begin
            phase_nxt = PH_CHUNK_ID;
            fi_nxt    = '0;
            tag_nxt   = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      bl_r    <= '0;
      tag_r   <= '0;
      rlen_r  <= '0;
      off_r   <= '0;
      ch_r    <= '0;
      bits_r  <= '0;
      rate_r  <= '0;
      fb_r    <= '0;
      fi_r    <= '0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bl_r    <= bl_nxt;
      tag_r   <= tag_nxt;
      rlen_r  <= rlen_nxt;
      off_r   <= off_nxt;
      ch_r    <= ch_nxt;
      bits_r  <= bits_nxt;
      rate_r  <= rate_nxt;
      fb_r    <= fb_nxt;
      fi_r    <= fi_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

### hw/rtl/wsp_queue.sv
// Short word queue between parser and output stage.
// Depends on wsp_pkg for the word type.
module wsp_queue
  import wsp_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  wsp_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output wsp_rec_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);

  wsp_rec_t      slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PtrLast) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PtrLast) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_rec;
  end

endmodule

### hw/rtl/wsp_back.sv
// Output stage: turns queued words into result fields, holds them.
// Depends on wsp_pkg; drains wsp_queue.
module wsp_back
  import wsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wsp_rec_t           q_head,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic [15:0]        out_channel_count,
  output logic [15:0]        out_sample_bits,
  output logic [31:0]        out_sample_rate
);

  logic        valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] left_r, left_nxt, right_r, right_nxt;
  logic [15:0] ch_r, ch_nxt, bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] lo8, hi8;

  // 8-bit PCM is offset binary: flip the sign bit and scale up
  assign lo8 = {~q_head.data[7],  q_head.data[6:0],  8'h00};
  assign hi8 = {~q_head.data[15], q_head.data[14:8], 8'h00};

  assign q_pop = !q_empty && (!valid_r || pop);
  assign empty = !valid_r;

  always_comb begin
    kind_nxt  = q_head.kind;
    left_nxt  = '0;
    right_nxt = '0;
    ch_nxt    = '0;
    bits_nxt  = '0;
    rate_nxt  = '0;
    case (q_head.kind)
      KIND_PAIR: begin
        if (q_head.wide8) begin
          left_nxt  = lo8;
          right_nxt = q_head.mono ? lo8 : hi8;
        end else begin
          left_nxt  = q_head.data[15:0];
          right_nxt = q_head.mono ? q_head.data[15:0] : q_head.data[31:16];
        end
      end
      KIND_FMT: begin
        ch_nxt   = q_head.data[15:0];
        bits_nxt = q_head.data[31:16];
        rate_nxt = q_head.data[63:32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= kind_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      ch_r    <= ch_nxt;
      bits_r  <= bits_nxt;
      rate_r  <= rate_nxt;
    end
  end

  assign out_kind          = kind_r;
  assign out_left_sample   = left_r;
  assign out_right_sample  = right_r;
  assign out_channel_count = ch_r;
  assign out_sample_bits   = bits_r;
  assign out_sample_rate   = rate_r;

endmodule

### hw/rtl/wav_stream_to_stereo_pcm16.sv
// WAV byte stream to stereo 16-bit PCM: one byte accepted per cycle while full is low.
// A result word reaches the out_ ports by way of the queue and the output register:
// the parser writes it into the queue, the output stage pops it and registers it.
// in full rises only when the word queue (QUEUE_DEPTH words) is full.
// rst_n is synchronous, active low; it clears parser, queue and output state.
// A byte carrying in_start_of_file restarts the parser before being parsed.
module wav_stream_to_stereo_pcm16
  import wsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte side
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte,
  input  logic               in_start_of_file,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic [15:0]        out_channel_count,
  output logic [15:0]        out_sample_bits,
  output logic [31:0]        out_sample_rate
);

  // Front: the parser. Every accepted byte updates its registered state
  // and yields at most one word (sample frame, format or error).
  logic     take;
  logic     rec_push;
  wsp_rec_t rec;

  // Queue between parser and output stage; decouples the two sides so a
  // stalled reader does not stop bytes until the queue fills.
  logic     q_empty, q_pop;
  wsp_rec_t q_head;

  assign take = push && !full;

  wsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .in_byte          (in_byte),
    .in_start_of_file (in_start_of_file),
    .rec_push         (rec_push),
    .rec              (rec)
  );

  wsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: widens 8-bit samples, copies mono to both sides and zeroes
  // fields that do not belong to the word's kind; holds the output word.
  wsp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_kind          (out_kind),
    .out_left_sample   (out_left_sample),
    .out_right_sample  (out_right_sample),
    .out_channel_count (out_channel_count),
    .out_sample_bits   (out_sample_bits),
    .out_sample_rate   (out_sample_rate)
  );

endmodule
